// File: src/reloading_timer_bank_defines.svh
// assertion helpers for the timer bank checker
`ifndef RELOADING_TIMER_BANK_DEFINES_SVH
`define RELOADING_TIMER_BANK_DEFINES_SVH

// same-cycle implication, off while reset is low
`define RTB_ASSERT_HOLD(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define RTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, checked during reset as well
`define RTB_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/rtb_pkg.sv
package rtb_pkg;

    localparam int ACT_W     = 3;
    localparam int CH_W      = 3;
    localparam int ELAPSED_W = 16;
    localparam int COUNT_W   = 32;
    localparam int MASK_W    = 8;
    localparam int REG_COUNT = 8;
    localparam int CFG_IDX_W = 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK   = 3'd0,
        ACT_RELOAD = 3'd1,
        ACT_STOP   = 3'd2,
        ACT_LOAD   = 3'd3,
        ACT_READ   = 3'd4
    } t_action;

    typedef struct packed {
        logic                we;
        logic [CH_W-1:0]     waddr;
        logic [COUNT_W-1:0]  wdata;
        logic [CH_W-1:0]     raddr;
    } t_mem_req;

    typedef struct packed {
        logic                 start;
        logic [ELAPSED_W-1:0] dividend;
        logic [COUNT_W-1:0]   divisor;
    } t_mod_req;

    typedef struct packed {
        logic                 done;
        logic [ELAPSED_W-1:0] rem;
    } t_mod_rsp;

endpackage

// File: src/rtb_in_if.sv
interface rtb_in_if;
    logic                          valid;
    logic                          ready;
    logic [rtb_pkg::ACT_W-1:0]     action;
    logic [rtb_pkg::CH_W-1:0]      channel;
    logic [rtb_pkg::ELAPSED_W-1:0] elapsed_ms;
    logic [rtb_pkg::COUNT_W-1:0]   load_value;

    modport source (output valid, action, channel, elapsed_ms, load_value, input ready);
    modport sink (input valid, action, channel, elapsed_ms, load_value, output ready);
endinterface

// File: src/rtb_out_if.sv
interface rtb_out_if;
    logic                        valid;
    logic                        ready;
    logic [rtb_pkg::MASK_W-1:0]  fired_mask;
    logic [rtb_pkg::COUNT_W-1:0] remaining;
    logic                        running;

    modport source (output valid, fired_mask, remaining, running, input ready);
    modport sink (input valid, fired_mask, remaining, running, output ready);
endinterface

// File: src/rtb_cfg_if.sv
interface rtb_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rtb_pkg::CFG_IDX_W-1:0] index;
    logic [rtb_pkg::COUNT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: src/reloading_timer_bank.sv
// channel  dir  fields                                     request taken when
// i_req    in   action channel elapsed_ms load_value       valid && ready
// o_rsp    out  fired_mask remaining running               valid && ready
// i_cfg    in   index data                                 valid && ready (ready always high)
//
// reload, stop, load and read pass through the OP, RD and FIN states before the next request is taken
// a tick with nonzero elapsed walks the counter memory through RD and EV for each channel,
// plus a pass through DIV for each firing channel with a nonzero interval (serial modulo)
// the counter memory needs no clear: a stopped channel reads out as 0 and is written before it runs
// a new request is taken while the previous result still waits in the output register
module reloading_timer_bank #(
    parameter int CHANNELS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rtb_in_if.sink    i_req,
    rtb_out_if.source o_rsp,
    rtb_cfg_if.sink   i_cfg
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW    = rtb_pkg::COUNT_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_OP   = 6'b000010,
        S_RD   = 6'b000100,
        S_EV   = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state                               r_state, n_state;
    logic                                 r_frd, n_frd;
    rtb_pkg::t_action                     r_act;
    logic [rtb_pkg::CH_W-1:0]             r_ch;
    logic [rtb_pkg::ELAPSED_W-1:0]        r_elapsed;
    logic [CW-1:0]                        r_value;
    logic [IDX_W-1:0]                     r_idx, n_idx;
    logic [rtb_pkg::MASK_W-1:0]           r_fired, n_fired;
    logic [CHANNELS-1:0]                  r_run, n_run;
    logic [CW-1:0]                        r_iv [rtb_pkg::REG_COUNT];

    logic                                 r_out_valid, n_out_valid;
    logic [rtb_pkg::MASK_W-1:0]           r_out_fired, n_out_fired;
    logic [CW-1:0]                        r_out_rem, n_out_rem;
    logic                                 r_out_run, n_out_run;

    rtb_pkg::t_mem_req                    mem_req;
    rtb_pkg::t_mod_req                    mod_req;
    rtb_pkg::t_mod_rsp                    mod_rsp;
    logic [CW-1:0]                        rdata;

    logic                                 in_acc;
    logic                                 ch_valid;
    logic [IDX_W-1:0]                     ch_idx;
    logic [rtb_pkg::CH_W-1:0]             walk_addr;
    logic [CW-1:0]                        iv_sel;
    logic [CW-1:0]                        elapsed_ext;
    logic                                 last;

    rtb_cnt_mem #(
        .DEPTH (CHANNELS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    rtb_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign in_acc      = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    assign ch_valid    = ({1'b0, r_ch} < (rtb_pkg::CH_W + 1)'(CHANNELS));
    assign ch_idx      = r_ch[IDX_W-1:0];
    assign walk_addr   = rtb_pkg::CH_W'(r_idx);
    assign iv_sel      = r_iv[(r_act == rtb_pkg::ACT_TICK) ? walk_addr : r_ch];
    assign elapsed_ext = CW'(r_elapsed);
    assign last        = (r_idx == IDX_W'(CHANNELS - 1));

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.fired_mask = r_out_fired;
    assign o_rsp.remaining  = r_out_rem;
    assign o_rsp.running    = r_out_run;

    always_comb begin
        n_state     = r_state;
        n_frd       = r_frd;
        n_idx       = r_idx;
        n_fired     = r_fired;
        n_run       = r_run;
        n_out_valid = r_out_valid;
        n_out_fired = r_out_fired;
        n_out_rem   = r_out_rem;
        n_out_run   = r_out_run;

        mem_req.we    = 1'b0;
        mem_req.waddr = r_ch;
        mem_req.wdata = '0;
        mem_req.raddr = r_ch;

        mod_req.start    = 1'b0;
        mod_req.dividend = r_elapsed - rdata[rtb_pkg::ELAPSED_W-1:0];
        mod_req.divisor  = iv_sel;

        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx   = '0;
                    n_fired = '0;
                    n_frd   = 1'b0;
                    if ((rtb_pkg::t_action'(i_req.action) == rtb_pkg::ACT_TICK)
                            && (i_req.elapsed_ms != '0)) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_OP;
                    end
                end
            end
            S_OP: begin
                if (ch_valid) begin
                    case (r_act)
                        rtb_pkg::ACT_RELOAD: begin
                            mem_req.we    = 1'b1;
                            mem_req.wdata = iv_sel;
                            n_run[ch_idx] = (iv_sel != '0);
                        end
                        rtb_pkg::ACT_STOP: begin
                            mem_req.we    = 1'b1;
                            n_run[ch_idx] = 1'b0;
                        end
                        rtb_pkg::ACT_LOAD: begin
                            mem_req.we    = 1'b1;
                            mem_req.wdata = r_value;
                            n_run[ch_idx] = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                n_state = S_RD;
                n_frd   = 1'b1;
            end
            S_RD: begin
                // final read of the addressed channel, or one step of the walk
                if (r_frd) begin
                    n_state = S_FIN;
                end else begin
                    mem_req.raddr = walk_addr;
                    n_state       = S_EV;
                end
            end
            S_EV: begin
                mem_req.waddr = walk_addr;
                mem_req.raddr = walk_addr;
                if (!r_run[r_idx]) begin
                    n_state = S_RD;
                end else if (rdata > elapsed_ext) begin
                    mem_req.we    = 1'b1;
                    mem_req.wdata = rdata - elapsed_ext;
                    n_state       = S_RD;
                end else if (iv_sel != '0) begin
                    mod_req.start = 1'b1;
                    n_state       = S_DIV;
                end else begin
                    mem_req.we   = 1'b1;
                    n_run[r_idx] = 1'b0;
                    n_fired      = r_fired | (rtb_pkg::MASK_W'(1) << r_idx);
                    n_state      = S_RD;
                end
                if (n_state == S_RD) begin
                    if (last) begin
                        n_frd = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_DIV: begin
                mem_req.waddr = walk_addr;
                if (mod_rsp.done) begin
                    mem_req.we    = 1'b1;
                    mem_req.wdata = iv_sel - CW'(mod_rsp.rem);
                    n_fired       = r_fired | (rtb_pkg::MASK_W'(1) << r_idx);
                    n_state       = S_RD;
                    if (last) begin
                        n_frd = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_fired = r_fired;
                    n_out_run   = ch_valid && r_run[ch_idx];
                    n_out_rem   = n_out_run ? rdata : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_frd       <= 1'b0;
            r_idx       <= '0;
            r_fired     <= '0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < rtb_pkg::REG_COUNT; i++) begin
                r_iv[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_frd       <= n_frd;
            r_idx       <= n_idx;
            r_fired     <= n_fired;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready
                    && (i_cfg.index < rtb_pkg::CFG_IDX_W'(rtb_pkg::REG_COUNT))) begin
                r_iv[i_cfg.index[rtb_pkg::CH_W-1:0]] <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_act     <= rtb_pkg::t_action'(i_req.action);
            r_ch      <= i_req.channel;
            r_elapsed <= i_req.elapsed_ms;
            r_value   <= i_req.load_value;
        end
        r_out_fired <= n_out_fired;
        r_out_rem   <= n_out_rem;
        r_out_run   <= n_out_run;
    end

endmodule

// File: src/rtb_mod.sv
module rtb_mod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rtb_pkg::t_mod_req i_req,
    output rtb_pkg::t_mod_rsp o_rsp
);

    localparam int DW     = rtb_pkg::ELAPSED_W;
    localparam int STEP_W = $clog2(DW + 1);

    logic                          r_busy;
    logic                          r_done;
    logic [STEP_W-1:0]             r_step;
    logic [DW-1:0]                 r_dvd;
    logic [DW-1:0]                 r_rem;
    logic [rtb_pkg::COUNT_W-1:0]   r_dvs;

    logic [DW:0]                   trial;
    logic [rtb_pkg::COUNT_W-1:0]   trial_ext;
    logic [rtb_pkg::COUNT_W-1:0]   diff;
    logic [DW-1:0]                 n_rem;

    // one restoring step per cycle
    always_comb begin
        trial     = {r_rem, r_dvd[DW-1]};
        trial_ext = rtb_pkg::COUNT_W'(trial);
        diff      = trial_ext - r_dvs;
        if (trial_ext >= r_dvs) begin
            n_rem = diff[DW-1:0];
        end else begin
            n_rem = trial[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// File: src/rtb_cnt_mem.sv
module rtb_cnt_mem #(
    parameter int DEPTH = 8
) (
    input  logic                        i_clk,
    input  rtb_pkg::t_mem_req           i_req,
    output logic [rtb_pkg::COUNT_W-1:0] o_rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [rtb_pkg::COUNT_W-1:0] r_mem [DEPTH];
    logic [rtb_pkg::COUNT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr[AW-1:0]];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/rtb_chk.sv
`include "reloading_timer_bank_defines.svh"

module rtb_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [rtb_pkg::COUNT_W-1:0] i_out_remaining,
    input logic                        i_out_running
);

    `RTB_ASSERT_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !i_out_valid, "result after reset")
    `RTB_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "request taken while busy")
    `RTB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_remaining) && $stable(i_out_running), "stalled result changed")
    `RTB_ASSERT_HOLD(a_stopped_zero, i_clk, i_rst_n, i_out_valid && !i_out_running, i_out_remaining == '0, "stopped channel with nonzero count")

endmodule

bind reloading_timer_bank rtb_chk u_rtb_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_req.valid),
    .i_in_ready      (i_req.ready),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_out_remaining (o_rsp.remaining),
    .i_out_running   (o_rsp.running)
);

// File: dv/reloading_timer_bank_tb.sv
module reloading_timer_bank_tb;

    localparam int NUM_CH      = 8;
    localparam int CLK_PERIOD  = 10;
    localparam int MAX_IDLE    = 13;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 200;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 135;
    localparam int HOLD_OFF    = 400;
    localparam int FLOOD_ITEMS = 16;
    localparam logic [rtb_pkg::ACT_W-1:0] ACT_UNUSED_LO =
        rtb_pkg::ACT_W'(rtb_pkg::ACT_READ + 1);
    localparam logic [rtb_pkg::ACT_W-1:0] ACT_UNUSED_HI = '1;

    typedef enum int {
        IVL_ALL_ZERO,
        IVL_ALL_MAX,
        IVL_MIXED
    } t_interval_mix;

    typedef struct {
        logic [rtb_pkg::MASK_W-1:0]  fired;
        logic [rtb_pkg::COUNT_W-1:0] remaining;
        logic                        running;
    } t_timer_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rtb_in_if  req_if ();
    rtb_out_if rsp_if ();
    rtb_cfg_if cfg_if ();

    reloading_timer_bank #(
        .CHANNELS(NUM_CH)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if),
        .i_cfg  (cfg_if)
    );

    // own copy of the timer bank state
    logic [rtb_pkg::COUNT_W-1:0] bank_count [NUM_CH];
    bit                          bank_running [NUM_CH];
    logic [rtb_pkg::COUNT_W-1:0] bank_interval [rtb_pkg::REG_COUNT];

    t_timer_result expected_results [$];

    bit src_idle;
    bit sink_idle;
    int hold_off_cycles;
    int n_err;
    int n_cycles;
    int n_cfg_writes;
    int n_firing_ticks;
    int n_holds;
    int n_by_action [1 << rtb_pkg::ACT_W];

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_timer_result timer_bank_step(
            logic [rtb_pkg::ACT_W-1:0] act,
            logic [rtb_pkg::CH_W-1:0] ch,
            logic [rtb_pkg::ELAPSED_W-1:0] elapsed,
            logic [rtb_pkg::COUNT_W-1:0] value);
        t_timer_result r;
        logic [rtb_pkg::COUNT_W-1:0] overshoot;
        logic [rtb_pkg::COUNT_W-1:0] elapsed_ext;
        bit ch_ok;
        r.fired = '0;
        elapsed_ext = rtb_pkg::COUNT_W'(elapsed);
        ch_ok = ch < NUM_CH;
        if (act == rtb_pkg::ACT_TICK) begin
            if (elapsed != '0) begin
                for (int i = 0; i < NUM_CH; i++) begin
                    if (!bank_running[i]) begin
                        continue;
                    end
                    if (bank_count[i] > elapsed_ext) begin
                        bank_count[i] = bank_count[i] - elapsed_ext;
                        continue;
                    end
                    if (bank_interval[i] != '0) begin
                        overshoot = elapsed_ext - bank_count[i];
                        bank_count[i] = bank_interval[i] - (overshoot % bank_interval[i]);
                    end else begin
                        bank_running[i] = 1'b0;
                        bank_count[i] = '0;
                    end
                    r.fired[i] = 1'b1;
                end
            end
        end else if (ch_ok) begin
            case (act)
                rtb_pkg::ACT_RELOAD: begin
                    bank_running[ch] = bank_interval[ch] != '0;
                    bank_count[ch] = bank_interval[ch];
                end
                rtb_pkg::ACT_STOP: begin
                    bank_running[ch] = 1'b0;
                    bank_count[ch] = '0;
                end
                rtb_pkg::ACT_LOAD: begin
                    bank_running[ch] = 1'b1;
                    bank_count[ch] = value;
                end
                default: ;
            endcase
        end
        r.remaining = ch_ok ? bank_count[ch] : '0;
        r.running = ch_ok && bank_running[ch];
        return r;
    endfunction

    task automatic check_field(string name, logic [rtb_pkg::COUNT_W-1:0] want,
                               logic [rtb_pkg::COUNT_W-1:0] got);
        if (want !== got) begin
            $error("%s expected %0h got %0h", name, want, got);
            n_err++;
        end
    endtask

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
                     expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    t_timer_result oldest;

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding");
                n_err++;
            end else begin
                oldest = expected_results.pop_front();
                check_field("fired_mask", rtb_pkg::COUNT_W'(oldest.fired),
                            rtb_pkg::COUNT_W'(rsp_if.fired_mask));
                check_field("remaining", oldest.remaining, rsp_if.remaining);
                check_field("running", rtb_pkg::COUNT_W'(oldest.running),
                            rtb_pkg::COUNT_W'(rsp_if.running));
            end
        end
    end

    // response side: random stalls plus an optional long hold-off
    initial begin : sink_side
        int stall;
        rsp_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off_cycles > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
                n_holds++;
            end
            stall = sink_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
        end
    end

    // valid stays high between back-to-back requests
    task automatic send_req(logic [rtb_pkg::ACT_W-1:0] act, logic [rtb_pkg::CH_W-1:0] ch,
                            logic [rtb_pkg::ELAPSED_W-1:0] elapsed,
                            logic [rtb_pkg::COUNT_W-1:0] value);
        int gap;
        t_timer_result r;
        gap = src_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.action     <= act;
        req_if.channel    <= ch;
        req_if.elapsed_ms <= elapsed;
        req_if.load_value <= value;
        do @(posedge i_clk); while (!req_if.ready);
        r = timer_bank_step(act, ch, elapsed, value);
        expected_results.push_back(r);
        n_by_action[act]++;
        if (act == rtb_pkg::ACT_TICK && r.fired != '0) begin
            n_firing_ticks++;
        end
    endtask

    task automatic send_random_req();
        int pick;
        int kind;
        logic [rtb_pkg::ACT_W-1:0] act;
        logic [rtb_pkg::ELAPSED_W-1:0] elapsed;
        logic [rtb_pkg::COUNT_W-1:0] value;
        pick = $urandom_range(0, 99);
        elapsed = rtb_pkg::ELAPSED_W'(($urandom_range(0, 7) == 0) ? $urandom
                                                                  : $urandom_range(0, 60));
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            value = '1;
        end else if (kind < 3) begin
            value = $urandom;
        end else begin
            value = $urandom_range(0, 300);
        end
        if (pick < 40) begin
            act = rtb_pkg::ACT_TICK;
        end else if (pick < 60) begin
            act = rtb_pkg::ACT_LOAD;
        end else if (pick < 75) begin
            act = rtb_pkg::ACT_RELOAD;
        end else if (pick < 83) begin
            act = rtb_pkg::ACT_STOP;
        end else if (pick < 95) begin
            act = rtb_pkg::ACT_READ;
        end else begin
            act = rtb_pkg::ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        end
        send_req(act, rtb_pkg::CH_W'($urandom_range(0, (1 << rtb_pkg::CH_W) - 1)),
                 elapsed, value);
    endtask

    task automatic write_cfg(logic [rtb_pkg::CFG_IDX_W-1:0] idx,
                             logic [rtb_pkg::COUNT_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx < rtb_pkg::CFG_IDX_W'(rtb_pkg::REG_COUNT)) begin
            bank_interval[idx[rtb_pkg::CH_W-1:0]] = data;
        end
        n_cfg_writes++;
    endtask

    task automatic wait_bank_idle();
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [rtb_pkg::COUNT_W-1:0] pick_interval(t_interval_mix mix);
        int kind;
        kind = $urandom_range(0, 5);
        if (mix == IVL_ALL_ZERO || (mix == IVL_MIXED && kind == 0)) begin
            return '0;
        end
        if (mix == IVL_ALL_MAX || kind == 1) begin
            return '1;
        end
        if (kind == 2) begin
            return $urandom;
        end
        return $urandom_range(1, 100);
    endfunction

    task automatic set_intervals(t_interval_mix mix);
        wait_bank_idle();
        for (int i = 0; i < rtb_pkg::REG_COUNT; i++) begin
            write_cfg(rtb_pkg::CFG_IDX_W'(i), pick_interval(mix));
        end
        // indexes past the register file are dropped
        write_cfg(rtb_pkg::CFG_IDX_W'($urandom_range(rtb_pkg::REG_COUNT,
                                                     (1 << rtb_pkg::CFG_IDX_W) - 1)),
                  $urandom);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_directed();
        src_idle = 1'b0;
        sink_idle = 1'b0;
        write_cfg(0, '0);
        write_cfg(1, 1);
        write_cfg(2, '1);
        write_cfg(3, 1000);
        write_cfg(4, 7);
        write_cfg(5, 32'h0000_FFFF);
        write_cfg(6, 32'h0001_0000);
        write_cfg(7, 3);
        write_cfg(rtb_pkg::CFG_IDX_W'(rtb_pkg::REG_COUNT), '1);
        write_cfg('1, 5);
        cfg_if.valid <= 1'b0;
        send_req(rtb_pkg::ACT_READ, 0, '1, '1);
        send_req(rtb_pkg::ACT_TICK, 3, 5, 0);
        send_req(rtb_pkg::ACT_LOAD, 0, 0, 10);
        send_req(rtb_pkg::ACT_LOAD, 2, 0, '1);
        send_req(rtb_pkg::ACT_LOAD, 4, 0, 0);
        send_req(rtb_pkg::ACT_RELOAD, 1, 0, 0);
        send_req(rtb_pkg::ACT_RELOAD, 3, 0, 0);
        send_req(rtb_pkg::ACT_RELOAD, 5, 0, 0);
        send_req(rtb_pkg::ACT_RELOAD, 6, 0, 0);
        send_req(rtb_pkg::ACT_TICK, 0, 0, '1);
        send_req(rtb_pkg::ACT_TICK, 4, 10, 0);
        send_req(rtb_pkg::ACT_READ, 0, 0, 0);
        send_req(rtb_pkg::ACT_TICK, 5, '1, 0);
        send_req(rtb_pkg::ACT_RELOAD, 0, 0, 0);
        send_req(rtb_pkg::ACT_STOP, 3, 0, 0);
        send_req(rtb_pkg::ACT_LOAD, 7, 0, 1);
        send_req(rtb_pkg::ACT_TICK, 7, 1, 0);
        send_req(rtb_pkg::ACT_READ, 2, 0, 0);
        send_req(ACT_UNUSED_LO, 1, '1, '1);
        send_req(ACT_UNUSED_HI, 7, 0, 0);
        send_req(rtb_pkg::ACT_RELOAD, 7, 0, 0);
        send_req(rtb_pkg::ACT_TICK, 7, '1, 0);
        send_req(rtb_pkg::ACT_STOP, 6, 0, 0);
        send_req(rtb_pkg::ACT_READ, 6, 0, 0);
    endtask

    task automatic test_random_phases();
        t_interval_mix mix;
        for (int p = 0; p < PHASES; p++) begin
            mix = (p == 0) ? IVL_ALL_ZERO : (p == 1) ? IVL_ALL_MAX : IVL_MIXED;
            set_intervals(mix);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 30 == 0) begin
                    src_idle = ($urandom_range(0, 1) != 0);
                    sink_idle = ($urandom_range(0, 1) != 0);
                end
                send_random_req();
            end
        end
    endtask

    // response side stalls long enough for the bank to back up into the request side
    task automatic test_backpressure();
        set_intervals(IVL_MIXED);
        src_idle = 1'b0;
        sink_idle = 1'b0;
        hold_off_cycles = HOLD_OFF;
        for (int k = 0; k < FLOOD_ITEMS; k++) begin
            send_random_req();
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_CH; i++) begin
            bank_count[i] = '0;
            bank_running[i] = 1'b0;
        end
        for (int i = 0; i < rtb_pkg::REG_COUNT; i++) begin
            bank_interval[i] = '0;
        end
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.action     <= rtb_pkg::ACT_TICK;
        req_if.channel    <= '0;
        req_if.elapsed_ms <= '0;
        req_if.load_value <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= '0;
        cfg_if.data       <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_phases();
        test_backpressure();

        wait_bank_idle();
        repeat (SETTLE) @(posedge i_clk);
        $display("%0d ticks (%0d firing), %0d loads, %0d reloads, %0d stops, %0d reads",
                 n_by_action[rtb_pkg::ACT_TICK], n_firing_ticks,
                 n_by_action[rtb_pkg::ACT_LOAD], n_by_action[rtb_pkg::ACT_RELOAD],
                 n_by_action[rtb_pkg::ACT_STOP], n_by_action[rtb_pkg::ACT_READ]);
        $display("%0d unused actions, %0d interval writes, %0d long hold-offs, %0d cycles",
                 n_by_action[ACT_UNUSED_LO] + n_by_action[ACT_UNUSED_LO + 1]
                 + n_by_action[ACT_UNUSED_HI], n_cfg_writes, n_holds, n_cycles);
        if (n_err == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
